// ===== hw/rtl/prp_pkg.sv =====
// Shared constants and types of the partial random permutation block.
package prp_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int SIZE_W = IDX_W + 1;
   localparam int WORD_W = 31;
   localparam int STEP_W = $clog2(WORD_W);
   localparam int EPOCH_W = 8;
   localparam int RAM_W = EPOCH_W + IDX_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_PERM_SIZE = 1'b0;
   localparam logic CSR_PICK_COUNT = 1'b1;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] remainder;
   } div_status_type;

endpackage

// ===== hw/rtl/prp_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module prp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (write) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/prp_divider.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module prp_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [prp_pkg::WORD_W-1:0]           dividend,
   input  logic [prp_pkg::SIZE_W-1:0]           divisor,
   output prp_pkg::div_status_type              status
);

   logic                               running_ff, running_in;
   logic [prp_pkg::STEP_W-1:0]         count_ff, count_in;
   logic [prp_pkg::WORD_W-1:0]         dividend_ff, dividend_in;
   logic [prp_pkg::SIZE_W-1:0]         divisor_ff, divisor_in;
   logic [prp_pkg::SIZE_W-1:0]         rem_ff, rem_in;
   logic [prp_pkg::SIZE_W:0]           shifted;
   logic [prp_pkg::SIZE_W:0]           diff;

   always_comb begin
      shifted = {rem_ff, dividend_ff[prp_pkg::WORD_W-1]};
      diff = shifted - {1'b0, divisor_ff};
      running_in = running_ff;
      count_in = count_ff;
      dividend_in = dividend_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      if (start) begin
         running_in = 1'b1;
         count_in = prp_pkg::STEP_W'(prp_pkg::WORD_W - 1);
         dividend_in = dividend;
         divisor_in = divisor;
         rem_in = '0;
      end else if (running_ff) begin
         dividend_in = {dividend_ff[prp_pkg::WORD_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = diff[prp_pkg::SIZE_W-1:0];
         end else begin
            rem_in = shifted[prp_pkg::SIZE_W-1:0];
         end
         if (count_ff == '0) begin
            running_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         running_ff <= running_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
   end

   assign status.done = ~running_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== hw/rtl/partial_random_permutation.sv =====
// Top level of the partial random permutation block.
// Each request carries one 31-bit random word and produces one response with the
// position i, the element placed there and tlast on the final pick of a run. On
// acceptance entry i is read and the bit-serial remainder unit starts; then entry j
// is read and entries i and j are written through the single port of the table RAM,
// the write of j waiting for the response register to be free. A request is taken
// only after the previous one has issued its response. Each table entry carries a
// run tag; an entry whose tag differs from the current one reads as its own index.
// After reset, and whenever the 8-bit tag wraps (every 255 completed or restarted
// runs), a clearing pass sweeps the table while no request is taken; register
// writes are accepted during it. Any register write restarts the run at position 0.
module partial_random_permutation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [31:0]                           req_tdata,   // random_word[30:0], zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [23:0]                           rsp_tdata,   // position[9:0], perm_value[19:10], zero
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [prp_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [prp_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [prp_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   typedef enum logic [2:0] {
      SWEEP, IDLE, READ_I, DIVIDE, READ_J, LOAD_J, WRITE_I, WRITE_J
   } state_type;

   state_type                          state_ff, state_in;
   logic [prp_pkg::SIZE_W-1:0]         perm_size_ff, perm_size_in;
   logic [prp_pkg::SIZE_W-1:0]         pick_count_ff, pick_count_in;
   logic [prp_pkg::IDX_W-1:0]          step_ff, step_in;
   logic [prp_pkg::EPOCH_W-1:0]        epoch_ff, epoch_in;
   logic [prp_pkg::IDX_W-1:0]          sweep_ff, sweep_in;
   logic [prp_pkg::IDX_W-1:0]          j_ff, j_in;
   logic [prp_pkg::IDX_W-1:0]          a_ff, a_in;
   logic [prp_pkg::IDX_W-1:0]          b_ff, b_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [prp_pkg::IDX_W-1:0]          rsp_position_ff, rsp_position_in;
   logic [prp_pkg::IDX_W-1:0]          rsp_value_ff, rsp_value_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [prp_pkg::SIZE_W-1:0]         eff_n;
   logic [prp_pkg::SIZE_W-1:0]         eff_k;
   logic [prp_pkg::SIZE_W-1:0]         step_ext;
   logic [prp_pkg::SIZE_W-1:0]         divisor;
   logic [prp_pkg::SIZE_W-1:0]         j_sum;
   logic                               last_step;
   logic                               req_accept;
   logic                               csr_write;
   logic                               rsp_free;
   logic                               tag_match;
   logic [prp_pkg::IDX_W-1:0]          entry_value;
   logic [prp_pkg::IDX_W-1:0]          read_addr_q;
   logic                               div_start;
   prp_pkg::div_status_type            div_status;

   logic                               ram_enable;
   logic                               ram_write;
   logic [prp_pkg::IDX_W-1:0]          ram_addr;
   logic [prp_pkg::RAM_W-1:0]          ram_wdata;
   logic [prp_pkg::RAM_W-1:0]          ram_rdata;

   prp_ram #(
      .DATA_W (prp_pkg::RAM_W),
      .DEPTH  (prp_pkg::MAX_ELEMENTS)
   ) u_table (
      .clock  (clock),
      .enable (ram_enable),
      .write  (ram_write),
      .addr   (ram_addr),
      .wdata  (ram_wdata),
      .rdata  (ram_rdata)
   );

   prp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[prp_pkg::WORD_W-1:0]),
      .divisor  (divisor),
      .status   (div_status)
   );

   always_comb begin
      eff_n = perm_size_ff;
      if (eff_n == '0) begin
         eff_n = prp_pkg::SIZE_W'(1);
      end
      if (eff_n > prp_pkg::SIZE_W'(prp_pkg::MAX_ELEMENTS)) begin
         eff_n = prp_pkg::SIZE_W'(prp_pkg::MAX_ELEMENTS);
      end
      eff_k = pick_count_ff;
      if (eff_k == '0) begin
         eff_k = prp_pkg::SIZE_W'(1);
      end
      if (eff_k > eff_n) begin
         eff_k = eff_n;
      end
   end

   assign step_ext = {1'b0, step_ff};
   assign divisor = eff_n - step_ext;
   assign j_sum = step_ext + div_status.remainder;
   assign last_step = (step_ext == eff_k - 1'b1);
   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign div_start = req_accept;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   assign read_addr_q = (state_ff == READ_I) ? step_ff : j_ff;
   assign tag_match = (ram_rdata[prp_pkg::RAM_W-1 -: prp_pkg::EPOCH_W] == epoch_ff);
   assign entry_value = tag_match ? ram_rdata[prp_pkg::IDX_W-1:0] : read_addr_q;

   always_comb begin
      ram_enable = 1'b0;
      ram_write = 1'b0;
      ram_addr = step_ff;
      ram_wdata = {epoch_ff, b_ff};
      unique case (state_ff)
         SWEEP: begin
            ram_enable = 1'b1;
            ram_write = 1'b1;
            ram_addr = sweep_ff;
            ram_wdata = '0;
         end
         IDLE: begin
            ram_enable = req_accept;
            ram_addr = step_ff;
         end
         READ_J: begin
            ram_enable = 1'b1;
            ram_addr = j_ff;
         end
         WRITE_I: begin
            ram_enable = 1'b1;
            ram_write = 1'b1;
            ram_addr = step_ff;
            ram_wdata = {epoch_ff, b_ff};
         end
         WRITE_J: begin
            ram_enable = rsp_free;
            ram_write = 1'b1;
            ram_addr = j_ff;
            ram_wdata = {epoch_ff, a_ff};
         end
         default: begin
            ram_enable = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      perm_size_in = perm_size_ff;
      pick_count_in = pick_count_ff;
      step_in = step_ff;
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      j_in = j_ff;
      a_in = a_ff;
      b_in = b_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_position_in = rsp_position_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_accept) begin
               state_in = READ_I;
            end
         end
         READ_I: begin
            a_in = entry_value;
            state_in = DIVIDE;
         end
         DIVIDE: begin
            if (div_status.done) begin
               j_in = j_sum[prp_pkg::IDX_W-1:0];
               state_in = READ_J;
            end
         end
         READ_J: begin
            state_in = LOAD_J;
         end
         LOAD_J: begin
            b_in = entry_value;
            state_in = WRITE_I;
         end
         WRITE_I: begin
            state_in = WRITE_J;
         end
         WRITE_J: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_position_in = step_ff;
               rsp_value_in = b_ff;
               rsp_last_in = last_step;
               state_in = IDLE;
               if (last_step) begin
                  step_in = '0;
                  if (epoch_ff == '1) begin
                     epoch_in = prp_pkg::EPOCH_W'(1);
                     sweep_in = '0;
                     state_in = SWEEP;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (csr_write) begin
         unique case (csr_paddr[2])
            prp_pkg::CSR_PERM_SIZE:  perm_size_in = csr_pwdata[prp_pkg::SIZE_W-1:0];
            prp_pkg::CSR_PICK_COUNT: pick_count_in = csr_pwdata[prp_pkg::SIZE_W-1:0];
            default:                 perm_size_in = perm_size_ff;
         endcase
         step_in = '0;
         if (state_ff != SWEEP) begin
            if (epoch_ff == '1) begin
               epoch_in = prp_pkg::EPOCH_W'(1);
               sweep_in = '0;
               state_in = SWEEP;
            end else begin
               epoch_in = epoch_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SWEEP;
         perm_size_ff <= prp_pkg::SIZE_W'(prp_pkg::MAX_ELEMENTS);
         pick_count_ff <= prp_pkg::SIZE_W'(prp_pkg::MAX_ELEMENTS);
         step_ff <= '0;
         epoch_ff <= prp_pkg::EPOCH_W'(1);
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         perm_size_ff <= perm_size_in;
         pick_count_ff <= pick_count_in;
         step_ff <= step_in;
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff <= j_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rsp_position_ff <= rsp_position_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      unique case (csr_paddr[2])
         prp_pkg::CSR_PERM_SIZE:  csr_prdata = prp_pkg::CSR_DATA_W'(perm_size_ff);
         prp_pkg::CSR_PICK_COUNT: csr_prdata = prp_pkg::CSR_DATA_W'(pick_count_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0, rsp_value_ff, rsp_position_ff};
   assign rsp_tlast = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (step_ext < eff_k))
      else $error("Request accepted with the step index outside the run.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE && div_status.done) |-> (j_sum < eff_n))
      else $error("Swap partner lies beyond the permutation size.");

   assert property (@(posedge clock) disable iff (reset)
      (ram_enable && ram_write && state_ff != SWEEP)
         |-> ({1'b0, ram_addr} < eff_n))
      else $error("Table write outside the active permutation.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == WRITE_J))
      else $error("Response raised outside the final write step.");
`endif

endmodule

// ===== tb/sv/partial_random_permutation_tb.sv =====
// Self-checking testbench for the partial random permutation block.
`timescale 1ns / 100ps

module partial_random_permutation_tb;

   localparam int TOTAL_WORDS = 1950;
   localparam int CALM_WORDS = 150;
   localparam int QUIET_LIMIT = 8000;
   localparam int DIRECTED_ROWS = 27;

   typedef struct packed {
      logic [prp_pkg::IDX_W-1:0] position;
      logic [prp_pkg::IDX_W-1:0] perm_value;
      logic                      last;
   } pick_type;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic                       csr_sel;
      logic [prp_pkg::SIZE_W-1:0] csr_value;
      logic [prp_pkg::WORD_W-1:0] word;
      logic                       known_valid;
      pick_type                   known;
   } plan_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [31:0]                    req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [23:0]                    rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [prp_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [prp_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [prp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   logic [prp_pkg::IDX_W-1:0]  perm_entry [prp_pkg::MAX_ELEMENTS];
   bit                         entry_live [prp_pkg::MAX_ELEMENTS];
   int unsigned                next_position;
   logic [prp_pkg::SIZE_W-1:0] size_setting;
   logic [prp_pkg::SIZE_W-1:0] pick_setting;

   pick_type    picks_due [$];
   int unsigned mismatches;
   int unsigned words_sent;
   int unsigned picks_seen;
   int unsigned quiet_cycles;
   bit          calm;
   bit          sender_jittery;
   bit          sink_jittery;

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd0, 1'b1, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h7FFFFFFF, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h2AAAAAAA, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h55555555, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PERM_SIZE, 11'd1, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PICK_COUNT, 11'd1, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd0, 1'b1, '{10'd0, 10'd0, 1'b1}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h7FFFFFFF, 1'b1, '{10'd0, 10'd0, 1'b1}},
      '{ROW_CSR, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd12345, 1'b1, '{10'd0, 10'd0, 1'b1}},
      '{ROW_CSR, prp_pkg::CSR_PERM_SIZE, 11'd2047, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PICK_COUNT, 11'd0, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd1023, 1'b1, '{10'd0, 10'd1023, 1'b1}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h7FFFFFFF, 1'b1,
        '{10'd0, 10'd1023, 1'b1}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd1024, 1'b1, '{10'd0, 10'd0, 1'b1}},
      '{ROW_CSR, prp_pkg::CSR_PERM_SIZE, 11'd4, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PICK_COUNT, 11'd2047, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd3, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h40000001, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd7, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'h7FFFFFFE, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd2, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PERM_SIZE, 11'd8, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PICK_COUNT, 11'd8, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd5, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_CSR, prp_pkg::CSR_PICK_COUNT, 11'd8, 31'd0, 1'b0, '{10'd0, 10'd0, 1'b0}},
      '{ROW_WORD, prp_pkg::CSR_PERM_SIZE, 11'd0, 31'd6, 1'b0, '{10'd0, 10'd0, 1'b0}}
   };

   partial_random_permutation dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // random_word[30:0], zero
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // position[9:0], perm_value[19:10], zero
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string note);
      $display("mismatch: %s", note);
      mismatches++;
   endtask

   function automatic pick_type forecast_pick(input logic [prp_pkg::WORD_W-1:0] word);
      int unsigned n;
      int unsigned k;
      int unsigned i;
      int unsigned j;
      int unsigned a;
      int unsigned b;
      pick_type result;
      n = (size_setting == 0) ? 1 : int'(size_setting);
      if (n > prp_pkg::MAX_ELEMENTS) n = prp_pkg::MAX_ELEMENTS;
      k = (pick_setting == 0) ? 1 : int'(pick_setting);
      if (k > n) k = n;
      if (next_position >= k) next_position = 0;
      if (next_position == 0) begin
         foreach (entry_live[e]) entry_live[e] = 1'b0;
      end
      i = next_position;
      j = i + (int'(word) % (n - i));
      a = entry_live[i] ? int'(perm_entry[i]) : i;
      b = entry_live[j] ? int'(perm_entry[j]) : j;
      perm_entry[i] = b[prp_pkg::IDX_W-1:0];
      perm_entry[j] = a[prp_pkg::IDX_W-1:0];
      entry_live[i] = 1'b1;
      entry_live[j] = 1'b1;
      result.position = i[prp_pkg::IDX_W-1:0];
      result.perm_value = b[prp_pkg::IDX_W-1:0];
      result.last = (i == k - 1);
      next_position = result.last ? 0 : i + 1;
      return result;
   endfunction

   function automatic logic [prp_pkg::SIZE_W-1:0] draw_setting();
      case ($urandom_range(0, 5))
         0: return 11'd0;
         1: return 11'd1;
         2: return 11'd1024;
         3: return 11'd2047;
         4: return 11'($urandom_range(2, 16));
         default: return 11'($urandom_range(1, 2047));
      endcase
   endfunction

   function automatic logic [prp_pkg::WORD_W-1:0] draw_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 31'($urandom_range(0, 2047));
         default: return 31'($urandom());
      endcase
   endfunction

   task automatic offer_word(input logic [prp_pkg::WORD_W-1:0] word, input bit known_valid,
                             input pick_type known);
      pick_type due;
      int unsigned gap;
      if (!calm && sender_jittery && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {1'b0, word};
      do @(posedge clock); while (!req_tready);
      due = forecast_pick(word);
      picks_due.push_back(known_valid ? known : due);
      words_sent++;
      if (words_sent >= TOTAL_WORDS - CALM_WORDS) calm = 1'b1;
   endtask

   // Register writes wait until every request in flight has produced its response.
   task automatic write_register(input logic sel, input logic [prp_pkg::SIZE_W-1:0] value);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (picks_due.size() != 0) @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {sel, 2'b00};
      csr_pwdata = {{(prp_pkg::CSR_DATA_W - prp_pkg::SIZE_W){1'b0}}, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == prp_pkg::CSR_PERM_SIZE) size_setting = value;
      else pick_setting = value;
      next_position = 0;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != {{(prp_pkg::CSR_DATA_W - prp_pkg::SIZE_W){1'b0}}, value})
         report_mismatch($sformatf("register at %0d reads %0d, expected %0d",
                                   csr_paddr, csr_prdata, value));
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned hold_left;
      int unsigned stall_left;
      bit held_once;
      pick_type want;
      hold_left = 0;
      stall_left = 0;
      held_once = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            picks_seen++;
            if (picks_due.size() == 0) begin
               report_mismatch($sformatf("unexpected response at position %0d",
                                         rsp_tdata[9:0]));
            end else begin
               want = picks_due.pop_front();
               if (rsp_tdata[9:0] != want.position)
                  report_mismatch($sformatf("response %0d position %0d, expected %0d",
                                            picks_seen, rsp_tdata[9:0], want.position));
               if (rsp_tdata[19:10] != want.perm_value)
                  report_mismatch($sformatf("response %0d value %0d, expected %0d",
                                            picks_seen, rsp_tdata[19:10],
                                            want.perm_value));
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("response %0d tlast %0b, expected %0b",
                                            picks_seen, rsp_tlast, want.last));
            end
         end
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (!held_once && picks_seen >= 150 && req_tvalid) begin
            // A long hold-off lets the block fill up and stall its request side.
            held_once = 1'b1;
            hold_left = 299;
            rsp_tready = 1'b0;
         end else if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (!calm && sink_jittery && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      int unsigned phase;
      int unsigned count;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      words_sent = 0;
      picks_seen = 0;
      quiet_cycles = 0;
      calm = 1'b0;
      sender_jittery = 1'b1;
      sink_jittery = 1'b1;
      size_setting = 11'd1024;
      pick_setting = 11'd1024;
      next_position = 0;
      foreach (entry_live[e]) begin
         entry_live[e] = 1'b0;
         perm_entry[e] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_CSR)
            write_register(directed_plan[r].csr_sel, directed_plan[r].csr_value);
         else
            offer_word(directed_plan[r].word, directed_plan[r].known_valid,
                       directed_plan[r].known);
      end

      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         sender_jittery = $urandom_range(0, 2) != 0;
         sink_jittery = $urandom_range(0, 2) != 0;
         if (phase == 1) begin
            // One full-size run reaches the top positions and values.
            write_register(prp_pkg::CSR_PERM_SIZE, 11'd1024);
            write_register(prp_pkg::CSR_PICK_COUNT, 11'd1024);
            count = 1024 + $urandom_range(0, 20);
         end else if (phase == 2) begin
            // Many one-step runs make the run tag wrap around.
            write_register(prp_pkg::CSR_PICK_COUNT, 11'd1);
            write_register(prp_pkg::CSR_PERM_SIZE, draw_setting());
            count = 270;
         end else if ($urandom_range(0, 1) == 0) begin
            write_register(prp_pkg::CSR_PERM_SIZE, draw_setting());
            write_register(prp_pkg::CSR_PICK_COUNT, draw_setting());
            count = $urandom_range(10, 90);
         end else begin
            write_register(prp_pkg::CSR_PICK_COUNT, draw_setting());
            write_register(prp_pkg::CSR_PERM_SIZE, draw_setting());
            count = $urandom_range(10, 90);
         end
         if (count > TOTAL_WORDS - words_sent) count = TOTAL_WORDS - words_sent;
         repeat (count) offer_word(draw_word(), 1'b0, '0);
         phase++;
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (picks_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/prp_pkg.sv
hw/rtl/prp_ram.sv
hw/rtl/prp_divider.sv
hw/rtl/partial_random_permutation.sv
tb/sv/partial_random_permutation_tb.sv
